@@ rtl/mlptlc_pkg.sv @@
`timescale 1ns / 1ps
package mlptlc_pkg;
  localparam int INPUT_COUNT = 3;
  localparam int HIDDEN_COUNT = 10;
  localparam int MAX_OUTPUTS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_LOAD_IW = 2'd0,
    MODE_LOAD_OW = 2'd1,
    MODE_LOAD_RL = 2'd2,
    MODE_EVAL    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_GOAL_X = 3'd0,
    CFG_GOAL_Y = 3'd1,
    CFG_GOAL_Z = 3'd2,
    CFG_INV_X  = 3'd3,
    CFG_INV_Y  = 3'd4,
    CFG_INV_Z  = 3'd5,
    CFG_OUT_CNT = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_SCALE,
    ST_HSUM,
    ST_HSIG,
    ST_HACT,
    ST_OSUM,
    ST_OSIG,
    ST_OACT,
    ST_TMUL,
    ST_TOUT,
    ST_WAIT
  } state_e;

  // controller commands to datapath
  typedef struct packed {
    logic load_err;
    logic scale;
    logic acc_clr;
    logic acc_mac_h;
    logic acc_mac_o;
    logic sig;
    logic store_h;
    logic store_o;
    logic tmul;
    logic push;
    logic [1:0] axis;
    logic [3:0] hid;
    logic [3:0] outk;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic logic [16:0] sig_tab(input logic [4:0] m);
    logic [16:0] r;
    case (m)
      5'd0: r = 17'd32768;  5'd1: r = 17'd40793;  5'd2: r = 17'd47911;
      5'd3: r = 17'd53581;  5'd4: r = 17'd57724;  5'd5: r = 17'd60565;
      5'd6: r = 17'd62428;  5'd7: r = 17'd63615;  5'd8: r = 17'd64357;
      5'd9: r = 17'd64816;  5'd10: r = 17'd65097; 5'd11: r = 17'd65269;
      5'd12: r = 17'd65374; 5'd13: r = 17'd65438; 5'd14: r = 17'd65476;
      5'd15: r = 17'd65500; 5'd16: r = 17'd65514;
      default: r = 17'd65514;
    endcase
    return r;
  endfunction
endpackage

@@ rtl/mlptlc_if.sv @@
`timescale 1ns / 1ps
interface mlptlc_in_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [7:0] load_index;
  logic signed [31:0] load_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, mode, load_index, load_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, mode, load_index, load_value, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface mlptlc_out_if;
  logic valid;
  logic ready;
  logic [3:0] output_index;
  logic [30:0] target_length;
  logic last;
  modport source (output valid, output_index, target_length, last, input ready);
  modport sink (input valid, output_index, target_length, last, output ready);
endinterface

@@ rtl/mlptlc_ctrl.sv @@
`timescale 1ns / 1ps
module mlptlc_ctrl
  import mlptlc_pkg::*;
#(
  parameter int HIDDEN = HIDDEN_COUNT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [4:0] n_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic busy_o
);
  state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [3:0] hid_q, hid_d;
  logic [3:0] k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q <= '0;
      hid_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      axis_q <= axis_d;
      hid_q <= hid_d;
      k_q <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d = axis_q;
    hid_d = hid_q;
    k_d = k_q;
    case (state_q)
      ST_IDLE: if (start_i) begin
        state_d = ST_ERR;
        hid_d = '0;
        k_d = '0;
        axis_d = '0;
      end
      ST_ERR: state_d = ST_SCALE;
      ST_SCALE: begin
        if (axis_q == 2'd2) begin
          axis_d = '0;
          state_d = ST_HSUM;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_HSUM: begin
        if (axis_q == 2'd2) begin
          axis_d = '0;
          state_d = ST_HSIG;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_HSIG: state_d = ST_HACT;
      ST_HACT: begin
        if (32'(hid_q) == HIDDEN - 1) begin
          hid_d = '0;
          state_d = ST_OSUM;
        end else begin
          hid_d = hid_q + 4'd1;
          state_d = ST_HSUM;
        end
      end
      ST_OSUM: begin
        if (32'(hid_q) == HIDDEN - 1) begin
          hid_d = '0;
          state_d = ST_OSIG;
        end else begin
          hid_d = hid_q + 4'd1;
        end
      end
      ST_OSIG: state_d = ST_OACT;
      ST_OACT: state_d = ST_TMUL;
      ST_TMUL: state_d = ST_TOUT;
      ST_TOUT: if (sts_i.out_free) begin
        if ({1'b0, k_q} + 5'd1 == n_i) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + 4'd1;
          state_d = ST_OSUM;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.axis = axis_q;
    cmd_o.hid = hid_q;
    cmd_o.outk = k_q;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_ERR: cmd_o.load_err = 1'b1;
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        cmd_o.acc_clr = (axis_q == 2'd2);
      end
      ST_HSUM: cmd_o.acc_mac_h = 1'b1;
      ST_HSIG: cmd_o.sig = 1'b1;
      ST_HACT: begin
        cmd_o.store_h = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_OSUM: cmd_o.acc_mac_o = 1'b1;
      ST_OSIG: cmd_o.sig = 1'b1;
      ST_OACT: begin
        cmd_o.store_o = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      ST_TMUL: cmd_o.tmul = 1'b1;
      ST_TOUT: cmd_o.push = sts_i.out_free;
      default: ;
    endcase
  end
endmodule

@@ rtl/mlptlc_dp.sv @@
`timescale 1ns / 1ps
module mlptlc_dp
  import mlptlc_pkg::*;
#(
  parameter int HIDDEN = HIDDEN_COUNT,
  parameter int MAXO = MAX_OUTPUTS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ld_we_i,
  input  logic [1:0] ld_mode_i,
  input  logic [7:0] ld_index_i,
  input  logic signed [31:0] ld_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] goal_x_i,
  input  logic signed [31:0] goal_y_i,
  input  logic signed [31:0] goal_z_i,
  input  logic signed [31:0] inv_x_i,
  input  logic signed [31:0] inv_y_i,
  input  logic signed [31:0] inv_z_i,
  input  logic [4:0] n_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  mlptlc_out_if.source out_if
);
  localparam int IW_DEPTH = INPUT_COUNT * HIDDEN;
  localparam int OW_DEPTH = HIDDEN * MAXO;
  localparam int OW_AW = $clog2(OW_DEPTH + 1);
  localparam logic signed [49:0] BIAS = 50'sd1 << 28;

  logic signed [15:0] iw_mem [IW_DEPTH];
  logic signed [15:0] ow_mem [OW_DEPTH];
  logic signed [31:0] rl_mem [MAXO];
  logic [16:0] hact_q [HIDDEN];

  logic signed [31:0] err_q [3];
  logic signed [31:0] xin_q [3];
  logic signed [49:0] acc_q;
  logic [16:0] act_q;
  logic signed [31:0] rest_q;
  logic signed [15:0] iw_rd_q, ow_rd_q;
  logic signed [53:0] prod_q;
  logic out_valid_q;
  logic [3:0] out_idx_q;
  logic [30:0] out_len_q;
  logic out_last_q;

  // loads
  always_ff @(posedge clk_i) begin
    if (ld_we_i) begin
      case (ld_mode_i)
        MODE_LOAD_IW: if (32'(ld_index_i) < IW_DEPTH)
          iw_mem[ld_index_i[$clog2(IW_DEPTH)-1:0]] <= ld_value_i[15:0];
        MODE_LOAD_OW: if (32'(ld_index_i) < OW_DEPTH)
          ow_mem[ld_index_i[$clog2(OW_DEPTH)-1:0]] <= ld_value_i[15:0];
        MODE_LOAD_RL: if (32'(ld_index_i) < MAXO)
          rl_mem[ld_index_i[$clog2(MAXO)-1:0]] <= ld_value_i;
        default: ;
      endcase
    end
  end

  // addresses for next-step weight fetch: registered read one state earlier is avoided
  // by reading each cycle at the address the next mac will use
  logic [7:0] iw_addr;
  logic [OW_AW-1:0] ow_addr;
  logic [1:0] nxt_axis;
  logic [3:0] nxt_hid;
  always_comb begin
    // the mac in the following cycle uses the controller's next indexes; derive them here
    nxt_axis = cmd_i.acc_mac_h ? ((cmd_i.axis == 2'd2) ? 2'd0 : cmd_i.axis + 2'd1) : 2'd0;
    nxt_hid = cmd_i.hid;
    if (cmd_i.store_h) nxt_hid = (32'(cmd_i.hid) == HIDDEN - 1) ? 4'd0 : cmd_i.hid + 4'd1;
    if (cmd_i.acc_mac_o) nxt_hid = (32'(cmd_i.hid) == HIDDEN - 1) ? 4'd0 : cmd_i.hid + 4'd1;
    iw_addr = 8'(32'(nxt_axis) * HIDDEN + 32'(nxt_hid));
    ow_addr = OW_AW'(32'(nxt_hid) * 32'(n_i) +
              32'(cmd_i.outk) + (cmd_i.push ? 32'd1 : 32'd0));
  end

  always_ff @(posedge clk_i) begin
    if (32'(iw_addr) < IW_DEPTH) iw_rd_q <= iw_mem[iw_addr[$clog2(IW_DEPTH)-1:0]];
    else iw_rd_q <= '0;
    if (32'(ow_addr) < OW_DEPTH) ow_rd_q <= ow_mem[ow_addr[$clog2(OW_DEPTH)-1:0]];
    else ow_rd_q <= '0;
    rest_q <= rl_mem[cmd_i.outk];
  end

  // error and scale
  logic signed [32:0] ediff [3];
  logic signed [31:0] goal_s [3], pos_s [3], inv_s [3];
  assign goal_s[0] = goal_x_i; assign goal_s[1] = goal_y_i; assign goal_s[2] = goal_z_i;
  assign pos_s[0] = pos_x_i; assign pos_s[1] = pos_y_i; assign pos_s[2] = pos_z_i;
  assign inv_s[0] = inv_x_i; assign inv_s[1] = inv_y_i; assign inv_s[2] = inv_z_i;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [63:0] sprod;
  logic signed [63:0] sshift;
  always_comb begin
    for (int i = 0; i < 3; i++) ediff[i] = 33'(goal_s[i]) - 33'(pos_s[i]);
    sprod = 64'(err_q[cmd_i.axis]) * 64'(inv_s[cmd_i.axis]);
    sshift = sprod >>> 24;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err)
      for (int i = 0; i < 3; i++) err_q[i] <= sat32(64'(ediff[i]));
    if (cmd_i.scale) xin_q[cmd_i.axis] <= sat32(sshift);
  end

  // mac: hidden uses x * iw, output uses act * ow
  logic signed [48:0] mprod;
  always_comb begin
    if (cmd_i.acc_mac_h) mprod = 49'(xin_q[cmd_i.axis]) * 49'(iw_rd_q);
    else mprod = 49'($signed({1'b0, hact_q[cmd_i.hid]})) * 49'(ow_rd_q);
  end

  // sigmoid
  logic signed [63:0] sum_sh;
  logic signed [31:0] sx;
  logic [31:0] amag;
  logic [4:0] seg;
  logic [14:0] frac;
  logic [16:0] t0, t1, sv;
  logic [31:0] interp;
  always_comb begin
    sum_sh = 64'(acc_q) >>> 12;
    sx = sat32(sum_sh);
    amag = sx[31] ? 32'(-33'(sx)) : 32'(sx);
    seg = amag[19:15];
    frac = amag[14:0];
    t0 = sig_tab(seg);
    t1 = sig_tab(seg + 5'd1);
    interp = 32'(t1 - t0) * 32'(frac);
    if (amag >= 32'h80000) sv = sig_tab(5'd16);
    else sv = t0 + 17'(interp >> 15);
    if (sx[31]) sv = 17'd65536 - sv;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) acc_q <= BIAS;
    else if (cmd_i.acc_mac_h || cmd_i.acc_mac_o) acc_q <= acc_q + 50'(mprod);
    if (cmd_i.sig) act_q <= sv;
    if (cmd_i.store_h) hact_q[cmd_i.hid] <= act_q;
    if (cmd_i.store_o || cmd_i.tmul)
      prod_q <= 54'($signed({1'b0, 21'(21'd15 * 21'(act_q) + 21'd65536)})) * 54'(rest_q);
  end

  logic [53:0] tsh;
  logic [30:0] tlen;
  always_comb begin
    tsh = 54'(prod_q) >> 18;
    if (prod_q < 0) tlen = '0;
    else if (tsh > 54'h7FFFFFFF) tlen = 31'h7FFFFFFF;
    else tlen = tsh[30:0];
  end

  assign sts_o.out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.push) out_valid_q <= 1'b1;
    else if (out_if.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_idx_q <= cmd_i.outk;
      out_len_q <= tlen;
      out_last_q <= ({1'b0, cmd_i.outk} + 5'd1 == n_i);
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.output_index = out_idx_q;
  assign out_if.target_length = out_len_q;
  assign out_if.last = out_last_q;
endmodule

@@ rtl/mlp_target_length_controller_unit.sv @@
`timescale 1ns / 1ps
// Target-length controller: load items (modes 0..2) write the weight and rest-length
// stores when taken; an evaluate item runs a 3-10-N perceptron on one shared
// multiply-accumulate and emits N target lengths, the final one with last set.
// An evaluate has the single accumulator walk every weight product in turn; the input
// is not taken again until the last result has been placed in the output register.
module mlp_target_length_controller_unit
  import mlptlc_pkg::*;
#(
  parameter int HIDDEN = HIDDEN_COUNT,
  parameter int MAXO = MAX_OUTPUTS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mlptlc_in_if.sink in_if,
  mlptlc_out_if.source out_if
);
  logic signed [31:0] goal_q [3];
  logic signed [31:0] inv_q [3];
  logic signed [31:0] pos_q [3];
  logic [4:0] ocnt_q;
  logic [4:0] n_eff;
  logic busy;
  logic acc;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        goal_q[i] <= '0;
        inv_q[i] <= 32'sd16777216;
      end
      ocnt_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GOAL_X: goal_q[0] <= cfg_data_i;
        CFG_GOAL_Y: goal_q[1] <= cfg_data_i;
        CFG_GOAL_Z: goal_q[2] <= cfg_data_i;
        CFG_INV_X: inv_q[0] <= cfg_data_i;
        CFG_INV_Y: inv_q[1] <= cfg_data_i;
        CFG_INV_Z: inv_q[2] <= cfg_data_i;
        CFG_OUT_CNT: ocnt_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // position is held from the evaluate transfer on
  always_ff @(posedge clk_i) begin
    if (acc && (in_if.mode == MODE_EVAL)) begin
      pos_q[0] <= in_if.pos_x;
      pos_q[1] <= in_if.pos_y;
      pos_q[2] <= in_if.pos_z;
    end
  end

  always_comb begin
    n_eff = ocnt_q;
    if (n_eff == 5'd0) n_eff = 5'd1;
    if (32'(n_eff) > MAXO) n_eff = 5'(MAXO);
  end

  assign in_if.ready = !busy;
  assign acc = in_if.valid && !busy;

  mlptlc_ctrl #(.HIDDEN(HIDDEN)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(acc && (in_if.mode == MODE_EVAL)),
    .n_i(n_eff),
    .sts_i(sts),
    .cmd_o(cmd),
    .busy_o(busy)
  );

  mlptlc_dp #(.HIDDEN(HIDDEN), .MAXO(MAXO)) u_dp (
    .clk_i, .rst_ni,
    .ld_we_i(acc && (in_if.mode != MODE_EVAL)),
    .ld_mode_i(in_if.mode),
    .ld_index_i(in_if.load_index),
    .ld_value_i(in_if.load_value),
    .pos_x_i(pos_q[0]), .pos_y_i(pos_q[1]), .pos_z_i(pos_q[2]),
    .goal_x_i(goal_q[0]), .goal_y_i(goal_q[1]), .goal_z_i(goal_q[2]),
    .inv_x_i(inv_q[0]), .inv_y_i(inv_q[1]), .inv_z_i(inv_q[2]),
    .n_i(n_eff),
    .cmd_i(cmd),
    .sts_o(sts),
    .out_if(out_if)
  );
endmodule

@@ dv/mlptlc_length_checker.sv @@
`timescale 1ns / 1ps
module mlptlc_length_checker
  import mlptlc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mlptlc_in_if                  in_mon,
  mlptlc_out_if                 out_mon,
  output int                    errors_o,
  output int                    pending_o
);
  typedef struct packed {
    logic [3:0]  idx;
    logic [30:0] len;
    logic        last;
  } length_t;

  localparam int IW_DEPTH = INPUT_COUNT * HIDDEN_COUNT;
  localparam int OW_DEPTH = HIDDEN_COUNT * MAX_OUTPUTS;

  int sig_pts [17];
  logic signed [31:0] goal [3];
  logic signed [31:0] inv_span [3];
  logic [4:0] out_cnt;
  logic signed [15:0] in_weights [IW_DEPTH];
  logic signed [15:0] out_weights [OW_DEPTH];
  logic signed [31:0] rest_len [MAX_OUTPUTS];
  length_t want_lengths [$];

  initial begin
    sig_pts = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
                64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // piecewise-linear logistic, unsigned Q0.16
  function automatic longint squash(longint x);
    longint a, v, lo, hi;
    int seg;
    a = (x < 0) ? -x : x;
    if (a >= 64'sd524288) begin
      v = sig_pts[16];
    end else begin
      seg = int'(a >>> 15);
      lo = sig_pts[seg];
      hi = sig_pts[seg + 1];
      v = lo + (((hi - lo) * (a & 64'sh7FFF)) >>> 15);
    end
    if (x < 0) v = 64'sd65536 - v;
    return v;
  endfunction

  task automatic predict_lengths(input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [31:0] pz);
    longint pos [3];
    longint x [3];
    longint hid [HIDDEN_COUNT];
    longint e, acc, o, p;
    int n;
    length_t r;
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
    n = (out_cnt == 0) ? 1 : ((out_cnt > MAX_OUTPUTS) ? MAX_OUTPUTS : int'(out_cnt));
    for (int i = 0; i < INPUT_COUNT; i++) begin
      e = clamp32(longint'(goal[i]) - pos[i]);
      x[i] = clamp32((e * longint'(inv_span[i])) >>> 24);
    end
    for (int j = 0; j < HIDDEN_COUNT; j++) begin
      acc = 64'sd1 <<< 28;
      for (int i = 0; i < INPUT_COUNT; i++)
        acc += x[i] * longint'(in_weights[i * HIDDEN_COUNT + j]);
      hid[j] = squash(clamp32(acc >>> 12));
    end
    for (int k = 0; k < n; k++) begin
      acc = 64'sd1 <<< 28;
      for (int j = 0; j < HIDDEN_COUNT; j++)
        acc += hid[j] * longint'(out_weights[j * n + k]);
      o = squash(clamp32(acc >>> 12));
      p = (15 * o + 64'sd65536) * longint'(rest_len[k]);
      if (p < 0) begin
        p = 0;
      end else begin
        p = p >>> 18;
        if (p > 64'sd2147483647) p = 64'sd2147483647;
      end
      r.idx = k[3:0];
      r.len = p[30:0];
      r.last = (k == n - 1);
      want_lengths.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    length_t w;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        goal[i] = '0;
        inv_span[i] = 32'sd16777216;
      end
      out_cnt = 5'd16;
      want_lengths.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GOAL_X: goal[0] = cfg_data_i;
          CFG_GOAL_Y: goal[1] = cfg_data_i;
          CFG_GOAL_Z: goal[2] = cfg_data_i;
          CFG_INV_X:  inv_span[0] = cfg_data_i;
          CFG_INV_Y:  inv_span[1] = cfg_data_i;
          CFG_INV_Z:  inv_span[2] = cfg_data_i;
          CFG_OUT_CNT: out_cnt = cfg_data_i[4:0];
          default: ;
        endcase
      end
      // results first: an evaluate taken at this edge cannot answer at it
      if (out_mon.valid && out_mon.ready) begin
        if (want_lengths.size() == 0) begin
          $display("%0t: result transfer with nothing expected: idx %0d len %0d last %0b",
                   $time, out_mon.output_index, out_mon.target_length, out_mon.last);
          errors_o++;
        end else begin
          w = want_lengths.pop_front();
          if (out_mon.output_index !== w.idx) begin
            $display("%0t: output_index expected %0d actual %0d", $time, w.idx,
                     out_mon.output_index);
            errors_o++;
          end
          if (out_mon.target_length !== w.len) begin
            $display("%0t: target_length expected %0d actual %0d (idx %0d)", $time, w.len,
                     out_mon.target_length, w.idx);
            errors_o++;
          end
          if (out_mon.last !== w.last) begin
            $display("%0t: last expected %0b actual %0b (idx %0d)", $time, w.last,
                     out_mon.last, w.idx);
            errors_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (mode_e'(in_mon.mode))
          MODE_LOAD_IW:
            if (in_mon.load_index < IW_DEPTH) in_weights[in_mon.load_index] = in_mon.load_value[15:0];
          MODE_LOAD_OW:
            if (in_mon.load_index < OW_DEPTH) out_weights[in_mon.load_index] = in_mon.load_value[15:0];
          MODE_LOAD_RL:
            if (in_mon.load_index < MAX_OUTPUTS) rest_len[in_mon.load_index] = in_mon.load_value;
          default: predict_lengths(in_mon.pos_x, in_mon.pos_y, in_mon.pos_z);
        endcase
      end
      pending_o = want_lengths.size();
    end
  end
endmodule

@@ dv/mlp_target_length_controller_unit_tb.sv @@
`timescale 1ns / 1ps
module mlp_target_length_controller_unit_tb;
  import mlptlc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int SQUEEZE_CYCLES = 600;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic calm = 1'b0;
  logic squeeze_req = 1'b0;
  int errors, pending, quiet_cycles;
  logic signed [31:0] cur_goal [3];

  mlptlc_in_if in_ch ();
  mlptlc_out_if out_ch ();

  mlp_target_length_controller_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  mlptlc_length_checker i_check (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_mon(in_ch), .out_mon(out_ch), .errors_o(errors),
    .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure, with one long hold-off on request
  initial begin
    logic squeeze_seen;
    squeeze_seen = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !squeeze_seen) begin
        squeeze_seen = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
      end
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send(mode_e mode, logic [7:0] idx, logic [31:0] val,
                      logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    if (!calm && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.load_index <= idx;
    in_ch.load_value <= val;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                           logic [31:0] ix, logic [31:0] iy, logic [31:0] iz, logic [4:0] cnt);
    drain();
    cfg_write(CFG_GOAL_X, gx);
    cfg_write(CFG_GOAL_Y, gy);
    cfg_write(CFG_GOAL_Z, gz);
    cfg_write(CFG_INV_X, ix);
    cfg_write(CFG_INV_Y, iy);
    cfg_write(CFG_INV_Z, iz);
    cfg_write(CFG_OUT_CNT, {27'($urandom_range(7)), cnt});
    cfg_write(UNUSED_REG, $urandom);
    cfg_we_i <= 1'b0;
    cur_goal[0] = gx;
    cur_goal[1] = gy;
    cur_goal[2] = gz;
  endtask

  function automatic logic [31:0] weight_val();
    logic [31:0] v;
    v = $urandom;
    // mostly modest weights so the sigmoid sees its middle segments
    if ($urandom_range(2) != 0) v[15:0] = 16'($signed($urandom_range(0, 4095)) - 2048);
    return v;
  endfunction

  function automatic logic [31:0] rest_val();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(32'h0040_0000);
  endfunction

  function automatic logic [31:0] near_pos(int axis);
    if ($urandom_range(3) == 0) return $urandom;
    return cur_goal[axis] + 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
  endfunction

  function automatic logic [31:0] span_val();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)
      send(MODE_EVAL, $urandom, $urandom, near_pos(0), near_pos(1), near_pos(2));
    else if (pick < 55)
      send(MODE_LOAD_IW, $urandom_range(0, 40) == 40 ? $urandom : $urandom_range(29),
           weight_val(), $urandom, $urandom, $urandom);
    else if (pick < 80)
      send(MODE_LOAD_OW, $urandom, weight_val(), $urandom, $urandom, $urandom);
    else
      send(MODE_LOAD_RL, $urandom_range(0, 20) == 20 ? $urandom : $urandom_range(15),
           rest_val(), $urandom, $urandom, $urandom);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD_IW;
    in_ch.load_index = '0;
    in_ch.load_value = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    quiet_cycles = 0;
    for (int i = 0; i < 3; i++) cur_goal[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every store entry gets written before the first evaluate
    for (int i = 0; i < INPUT_COUNT * HIDDEN_COUNT; i++)
      send(MODE_LOAD_IW, i, weight_val(), $urandom, $urandom, $urandom);
    for (int i = 0; i < HIDDEN_COUNT * MAX_OUTPUTS; i++)
      send(MODE_LOAD_OW, i, weight_val(), $urandom, $urandom, $urandom);
    for (int i = 0; i < MAX_OUTPUTS; i++)
      send(MODE_LOAD_RL, i, rest_val(), $urandom, $urandom, $urandom);

    send(MODE_EVAL, 8'hFF, 32'hFFFF_FFFF, '0, '0, '0);
    send(MODE_EVAL, '0, '0, S32_MAX, S32_MAX, S32_MAX);
    send(MODE_EVAL, '0, '0, S32_MIN, S32_MIN, S32_MIN);
    send(MODE_EVAL, '0, '0, S32_MAX, S32_MIN, 32'h5555_5555);
    // addresses past the end of each store are dropped
    send(MODE_LOAD_IW, 8'd30, $urandom, '0, '0, '0);
    send(MODE_LOAD_IW, 8'd255, $urandom, '0, '0, '0);
    send(MODE_LOAD_OW, 8'd160, $urandom, '0, '0, '0);
    send(MODE_LOAD_RL, 8'd16, $urandom, '0, '0, '0);
    send(MODE_LOAD_RL, 8'd255, $urandom, '0, '0, '0);
    send(MODE_LOAD_IW, 8'd0, 32'h0000_7FFF, '0, '0, '0);
    send(MODE_LOAD_IW, 8'd1, 32'hFFFF_8000, '0, '0, '0);
    send(MODE_LOAD_OW, 8'd0, 32'h0000_7FFF, '0, '0, '0);
    send(MODE_LOAD_OW, 8'd1, 32'hFFFF_8000, '0, '0, '0);
    send(MODE_LOAD_RL, 8'd0, 32'h7FFF_FFFF, '0, '0, '0);
    send(MODE_LOAD_RL, 8'd1, 32'h8000_0000, '0, '0, '0);
    send(MODE_EVAL, '0, '0, 32'h0001_0000, 32'hFFFF_0000, '0);

    apply_cfg(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 5'd1);
    send(MODE_EVAL, '0, '0, S32_MIN, S32_MIN, S32_MIN);
    send(MODE_EVAL, '0, '0, S32_MAX, S32_MAX, S32_MAX);
    apply_cfg(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 5'd0);
    send(MODE_EVAL, '0, '0, S32_MAX, S32_MAX, S32_MAX);
    send(MODE_EVAL, '0, '0, '0, '0, '0);
    apply_cfg($urandom, $urandom, $urandom, '0, '0, '0, 5'd31);
    send(MODE_EVAL, '0, '0, $urandom, $urandom, $urandom);

    for (int ph = 0; ph < 5; ph++) begin
      apply_cfg($urandom, $urandom, $urandom, span_val(), span_val(), span_val(),
                (ph == 4) ? 5'd16 : 5'($urandom_range(1, 16)));
      calm <= (ph == 2);
      if (ph == 3) begin
        squeeze_req <= 1'b1;
        // an evaluate up front so the held-off results back up into the input
        send(MODE_EVAL, '0, '0, near_pos(0), near_pos(1), near_pos(2));
      end
      for (int n = 0; n < 6; n++) random_item();
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
